[design/kvat_pkg.sv]
// Shared constants, codes and controller/datapath types for the keyed vector accumulator table.
package kvat_pkg;

  localparam int DEF_TABLE_DEPTH     = 256;
  localparam int DEF_COMPONENT_WIDTH = 32;
  localparam int DEF_KEY_WIDTH       = 32;

  localparam int ACTION_W   = 3;
  localparam int KEY_IN_W   = 32;
  localparam int FORCE_W    = 32;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int TOTAL_W    = 9;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_reg_e;

  // What the datapath loads into the result register
  typedef enum logic [2:0] {
    RES_ZERO   = 3'd0,
    RES_VEC    = 3'd1,
    RES_ADD    = 3'd2,
    RES_APPEND = 3'd3,
    RES_ENTRY  = 3'd4
  } res_e;

  typedef struct packed {
    logic    latch;
    logic    scan_step;
    logic    rd_idx;
    logic    rd_last;
    logic    rem_wr;
    logic    clear;
    logic    res_load;
    res_e    res_kind;
    status_e res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                reserved;
    logic                idx_ok;
    logic                hit;
    logic                miss;
    logic                full;
    logic                out_free;
  } dp_stat_t;

endpackage

[design/kvat_in_if.sv]
// Input item channel: valid/ready handshake with the request payload.
interface kvat_in_if;
  import kvat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [KEY_IN_W-1:0]       entity_key;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;
  logic [SLOT_W-1:0]         slot_index;

  modport source (output valid, action, entity_key, force_x, force_y, force_z, slot_index,
                  input ready);
  modport sink   (input valid, action, entity_key, force_x, force_y, force_z, slot_index,
                  output ready);
endinterface

[design/kvat_out_if.sv]
// Result item channel: valid/ready handshake with the response payload.
interface kvat_out_if;
  import kvat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [KEY_IN_W-1:0]       out_key;
  logic signed [FORCE_W-1:0] out_x;
  logic signed [FORCE_W-1:0] out_y;
  logic signed [FORCE_W-1:0] out_z;
  logic [TOTAL_W-1:0]        entry_total;

  modport source (output valid, status, out_key, out_x, out_y, out_z, entry_total,
                  input ready);
  modport sink   (input valid, status, out_key, out_x, out_y, out_z, entry_total,
                  output ready);
endinterface

[design/keyed_vector_accumulator_table.sv]
// Keyed vector accumulator table: a packed table of keys with saturating three-component
// vectors, serving add, lookup, remove (last entry fills the hole), clear and read-at-index.
// One item is handled at a time. Add, lookup and remove scan the valid entries through the
// single read port of the key memory, one entry per cycle; a hit stops the scan early, and
// a remove hit then moves the last entry into the hit slot. Clear, read-at-index and items
// rejected at decode skip the scan. A result waiting in the output
// register does not block the next item from being accepted. The entry memories are not
// cleared after reset; only the entry count is.
module keyed_vector_accumulator_table #(
  parameter int TABLE_DEPTH     = kvat_pkg::DEF_TABLE_DEPTH,
  parameter int COMPONENT_WIDTH = kvat_pkg::DEF_COMPONENT_WIDTH,
  parameter int KEY_WIDTH       = kvat_pkg::DEF_KEY_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kvat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kvat_pkg::CFG_DATA_W-1:0] cfg_data_i,
  kvat_in_if.sink                         in_i,
  kvat_out_if.source                      out_o
);
  import kvat_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_i.ready = in_ready;

  kvat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kvat_dp #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .KEY_WIDTH       (KEY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (in_i.action),
    .entity_key_i  (in_i.entity_key),
    .force_x_i     (in_i.force_x),
    .force_y_i     (in_i.force_y),
    .force_z_i     (in_i.force_z),
    .slot_index_i  (in_i.slot_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .out_key_o     (out_o.out_key),
    .out_x_o       (out_o.out_x),
    .out_y_o       (out_o.out_y),
    .out_z_o       (out_o.out_z),
    .entry_total_o (out_o.entry_total)
  );

endmodule

[design/kvat_ctrl.sv]
// Sequencing state machine: decode, linear scan, remove move and result hand-off.
module kvat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kvat_pkg::dp_stat_t stat_i,
  output kvat_pkg::dp_cmd_t  cmd_o
);
  import kvat_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_READ   = 6'b001000,
    S_REM_WR = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   keyed;

  assign in_ready_o = (state_q == S_IDLE);
  assign keyed = (stat_i.act == ACT_ADD) || (stat_i.act == ACT_LOOKUP) ||
                 (stat_i.act == ACT_REMOVE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_kind   = RES_ZERO;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (keyed && stat_i.reserved) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_RESERVED;
          state_d          = S_DONE;
        end else begin
          unique case (stat_i.act) inside
            ACT_ADD, ACT_LOOKUP, ACT_REMOVE: state_d = S_SCAN;
            ACT_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.res_load = 1'b1;
              state_d        = S_DONE;
            end
            ACT_READ: begin
              if (stat_i.idx_ok) begin
                cmd_o.rd_idx = 1'b1;
                state_d      = S_READ;
              end else begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_RANGE;
                state_d          = S_DONE;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
              state_d        = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          unique case (stat_i.act) inside
            ACT_ADD: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RES_ADD;
              state_d        = S_DONE;
            end
            ACT_LOOKUP: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RES_VEC;
              state_d        = S_DONE;
            end
            default: begin
              cmd_o.rd_last = 1'b1;
              state_d       = S_REM_WR;
            end
          endcase
        end else if (stat_i.miss) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          if (stat_i.act == ACT_ADD) begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.res_kind = RES_APPEND;
            end
          end else begin
            cmd_o.res_status = ST_NOT_FOUND;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = RES_ENTRY;
        state_d        = S_DONE;
      end
      S_REM_WR: begin
        cmd_o.rem_wr   = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/kvat_dp.sv]
// Datapath: entry memories, scan counters, saturating adders, config and result registers.
module kvat_dp #(
  parameter int TABLE_DEPTH     = kvat_pkg::DEF_TABLE_DEPTH,
  parameter int COMPONENT_WIDTH = kvat_pkg::DEF_COMPONENT_WIDTH,
  parameter int KEY_WIDTH       = kvat_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kvat_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kvat_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [kvat_pkg::ACTION_W-1:0]       action_i,
  input  logic [kvat_pkg::KEY_IN_W-1:0]       entity_key_i,
  input  logic signed [kvat_pkg::FORCE_W-1:0] force_x_i,
  input  logic signed [kvat_pkg::FORCE_W-1:0] force_y_i,
  input  logic signed [kvat_pkg::FORCE_W-1:0] force_z_i,
  input  logic [kvat_pkg::SLOT_W-1:0]         slot_index_i,
  input  kvat_pkg::dp_cmd_t                   cmd_i,
  output kvat_pkg::dp_stat_t                  stat_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [kvat_pkg::STATUS_W-1:0]       status_o,
  output logic [kvat_pkg::KEY_IN_W-1:0]       out_key_o,
  output logic signed [kvat_pkg::FORCE_W-1:0] out_x_o,
  output logic signed [kvat_pkg::FORCE_W-1:0] out_y_o,
  output logic signed [kvat_pkg::FORCE_W-1:0] out_z_o,
  output logic [kvat_pkg::TOTAL_W-1:0]        entry_total_o
);
  import kvat_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  localparam logic signed [FORCE_W-1:0] IN_HI =
    $signed({{(FORCE_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [FORCE_W-1:0] IN_LO =
    $signed({{(FORCE_W-CW+1){1'b1}}, {(CW-1){1'b0}}});

  function automatic logic signed [CW-1:0] clamp_in(input logic signed [FORCE_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > IN_HI) begin
      r = IN_HI[CW-1:0];
    end else if (v < IN_LO) begin
      r = IN_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0]   s;
    logic signed [CW-1:0] r;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s[CW] != s[CW-1]) begin
      r = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = s[CW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [CAP_W-1:0]      cap_q;
  logic [CFG_DATA_W-1:0] rsv_q;

  // latched request
  logic [ACTION_W-1:0]  act_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic signed [CW-1:0] fx_q, fy_q, fz_q;
  logic [SLOT_W-1:0]    slot_q;

  // table state
  logic [CNTW-1:0] count_q;
  logic [CNTW-1:0] issue_q;
  logic            pend_q;
  logic [AW-1:0]   pos_q;

  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
  logic [3*CW-1:0]      vec_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] key_rd_q;
  logic [3*CW-1:0]      vec_rd_q;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [3*CW-1:0]      wr_vec;
  logic [CNTW-1:0]      last_idx;

  logic signed [CW-1:0] rd_x, rd_y, rd_z, sum_x, sum_y, sum_z;
  logic                 hit;
  logic [31:0]          eff_cap;

  // result and output registers
  logic [STATUS_W-1:0]       res_status_q, out_status_q;
  logic [KEY_IN_W-1:0]       res_key_q, out_key_q;
  logic signed [FORCE_W-1:0] res_x_q, res_y_q, res_z_q, out_x_q, out_y_q, out_z_q;
  logic [TOTAL_W-1:0]        out_total_q;
  logic                      out_vld_q;

  assign rd_x  = vec_rd_q[CW-1:0];
  assign rd_y  = vec_rd_q[2*CW-1:CW];
  assign rd_z  = vec_rd_q[3*CW-1:2*CW];
  assign sum_x = sat_add(rd_x, fx_q);
  assign sum_y = sat_add(rd_y, fy_q);
  assign sum_z = sat_add(rd_z, fz_q);

  assign last_idx = count_q - 1'b1;
  assign hit      = pend_q && (key_rd_q == key_q);
  assign eff_cap  = (32'(cap_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(cap_q);

  assign stat_o.act      = act_q;
  assign stat_o.reserved = (key_q == rsv_q[KEY_WIDTH-1:0]);
  assign stat_o.idx_ok   = (32'(slot_q) < 32'(count_q)) && (32'(slot_q) < 32'(TABLE_DEPTH));
  assign stat_o.hit      = hit;
  assign stat_o.miss     = !hit && (issue_q >= count_q);
  assign stat_o.full     = (32'(count_q) >= eff_cap);
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  // memory port control
  always_comb begin
    rd_en = cmd_i.scan_step || cmd_i.rd_idx || cmd_i.rd_last;
    if (cmd_i.rd_idx) begin
      rd_addr = AW'(slot_q);
    end else if (cmd_i.rd_last) begin
      rd_addr = last_idx[AW-1:0];
    end else begin
      rd_addr = issue_q[AW-1:0];
    end

    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_key  = key_q;
    wr_vec  = {sum_z, sum_y, sum_x};
    if (cmd_i.rem_wr) begin
      wr_en  = 1'b1;
      wr_key = key_rd_q;
      wr_vec = vec_rd_q;
    end else if (cmd_i.res_load && (cmd_i.res_kind == RES_ADD)) begin
      wr_en = 1'b1;
    end else if (cmd_i.res_load && (cmd_i.res_kind == RES_APPEND)) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_vec  = {fz_q, fy_q, fx_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      vec_mem[wr_addr] <= wr_vec;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      vec_rd_q <= vec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      rsv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY: cap_q <= cfg_data_i[CAP_W-1:0];
        CFG_RESERVED: rsv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      key_q  <= entity_key_i[KEY_WIDTH-1:0];
      fx_q   <= clamp_in(force_x_i);
      fy_q   <= clamp_in(force_y_i);
      fz_q   <= clamp_in(force_z_i);
      slot_q <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      issue_q <= '0;
      pend_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.latch) begin
        issue_q <= '0;
        pend_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        issue_q <= issue_q + 1'b1;
        pend_q  <= 1'b1;
        pos_q   <= issue_q[AW-1:0];
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.rem_wr) begin
        count_q <= last_idx;
      end else if (cmd_i.res_load && (cmd_i.res_kind == RES_APPEND)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_key_q    <= '0;
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_z_q      <= '0;
      case (cmd_i.res_kind)
        RES_VEC: begin
          res_x_q <= FORCE_W'(rd_x);
          res_y_q <= FORCE_W'(rd_y);
          res_z_q <= FORCE_W'(rd_z);
        end
        RES_ADD: begin
          res_x_q <= FORCE_W'(sum_x);
          res_y_q <= FORCE_W'(sum_y);
          res_z_q <= FORCE_W'(sum_z);
        end
        RES_APPEND: begin
          res_x_q <= FORCE_W'(fx_q);
          res_y_q <= FORCE_W'(fy_q);
          res_z_q <= FORCE_W'(fz_q);
        end
        RES_ENTRY: begin
          res_key_q <= KEY_IN_W'(key_rd_q);
          res_x_q   <= FORCE_W'(rd_x);
          res_y_q   <= FORCE_W'(rd_y);
          res_z_q   <= FORCE_W'(rd_z);
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_z_q      <= res_z_q;
      out_total_q  <= TOTAL_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign out_key_o     = out_key_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign entry_total_o = out_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (32'(wr_addr) <= 32'(count_q)) && (32'(wr_addr) < 32'(TABLE_DEPTH)))
    else $error("table write outside packed region");

  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_load && (cmd_i.res_kind == RES_APPEND)) |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the table by one");

  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem_wr |-> (count_q != '0) && (32'(pos_q) < 32'(count_q)))
    else $error("remove move with empty table or stale slot");

endmodule

[tb/keyed_vector_accumulator_table_tb.sv]
// Self-checking testbench for the keyed vector accumulator table.
`timescale 1ns / 100ps

module keyed_vector_accumulator_table_tb;
  import kvat_pkg::*;

  localparam int          TBL_DEPTH     = DEF_TABLE_DEPTH;
  localparam int          POOL_N        = 24;
  localparam int          SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned HOLD_AT       = 600;
  localparam int unsigned HOLD_LEN      = 1500;
  localparam int          UNUSED_ACT_LO = int'(ACT_READ) + 1;
  localparam int          UNUSED_ACT_HI = (1 << ACTION_W) - 1;
  localparam logic [FORCE_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [FORCE_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [FORCE_W-1:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [KEY_IN_W-1:0]     key;
    logic [2:0][FORCE_W-1:0] frc;
    logic [SLOT_W-1:0]       slot;
  } request_t;

  typedef struct packed {
    status_e                 status;
    logic [KEY_IN_W-1:0]     key;
    logic [2:0][FORCE_W-1:0] vec;
    logic [TOTAL_W-1:0]      total;
  } response_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kvat_in_if  in_if ();
  kvat_out_if out_if ();

  keyed_vector_accumulator_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow table and registers
  logic [KEY_IN_W-1:0]     tbl_key [TBL_DEPTH];
  logic [2:0][FORCE_W-1:0] tbl_vec [TBL_DEPTH];
  int unsigned             tbl_count;
  logic [CAP_W-1:0]        cap_reg;
  logic [CFG_DATA_W-1:0]   resv_reg;

  request_t    request_q[$];
  response_t   response_q[$];
  logic [KEY_IN_W-1:0] key_pool [POOL_N];
  request_t    tx_item;
  response_t   want;
  int unsigned tx_gap, tx_calm, rx_gap, rx_calm, rx_hold;
  bit          hold_done;
  int unsigned queued_total, responses_seen, fail_cnt, cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [FORCE_W-1:0] sat_add(logic [FORCE_W-1:0] a, logic [FORCE_W-1:0] b);
    logic signed [FORCE_W:0] s;
    s = $signed({a[FORCE_W-1], a}) + $signed({b[FORCE_W-1], b});
    if (s[FORCE_W] != s[FORCE_W-1]) return s[FORCE_W] ? Q_MIN : Q_MAX;
    return s[FORCE_W-1:0];
  endfunction

  function automatic int find_slot(logic [KEY_IN_W-1:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic response_t apply_to_table(request_t r);
    response_t   rsp;
    int          slot;
    int unsigned cap_eff;
    rsp = '0;
    rsp.status = ST_OK;
    cap_eff = (cap_reg > TBL_DEPTH) ? TBL_DEPTH : cap_reg;
    if (r.action <= ACT_REMOVE && r.key == resv_reg) begin
      rsp.status = ST_RESERVED;
    end else begin
      case (r.action)
        ACT_ADD: begin
          slot = find_slot(r.key);
          if (slot >= 0) begin
            for (int c = 0; c < 3; c++) tbl_vec[slot][c] = sat_add(tbl_vec[slot][c], r.frc[c]);
            rsp.vec = tbl_vec[slot];
          end else if (tbl_count >= cap_eff) begin
            rsp.status = ST_FULL;
          end else begin
            tbl_key[tbl_count] = r.key;
            tbl_vec[tbl_count] = r.frc;
            rsp.vec = r.frc;
            tbl_count++;
          end
        end
        ACT_LOOKUP: begin
          slot = find_slot(r.key);
          if (slot >= 0) rsp.vec = tbl_vec[slot];
          else rsp.status = ST_NOT_FOUND;
        end
        ACT_REMOVE: begin
          slot = find_slot(r.key);
          if (slot >= 0) begin
            tbl_key[slot] = tbl_key[tbl_count-1];
            tbl_vec[slot] = tbl_vec[tbl_count-1];
            tbl_count--;
          end else begin
            rsp.status = ST_NOT_FOUND;
          end
        end
        ACT_CLEAR: tbl_count = 0;
        ACT_READ: begin
          if (r.slot < tbl_count) begin
            rsp.key = tbl_key[r.slot];
            rsp.vec = tbl_vec[r.slot];
          end else begin
            rsp.status = ST_RANGE;
          end
        end
        default: ;
      endcase
    end
    rsp.total = tbl_count[TOTAL_W-1:0];
    return rsp;
  endfunction

  // Mostly short pauses, some long ones, and now and then a calm stretch with none
  function automatic int unsigned pick_pause(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key(int unsigned new_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return resv_reg;
    if (r < 4 + new_pct) return $urandom();
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [FORCE_W-1:0] pick_force();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FORCE_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    if (r < 55) return Q_MAX;
    if (r < 65) return Q_MIN;
    return $urandom();
  endfunction

  task automatic queue_request(logic [ACTION_W-1:0] act, logic [KEY_IN_W-1:0] key,
                               logic [FORCE_W-1:0] fx, logic [FORCE_W-1:0] fy,
                               logic [FORCE_W-1:0] fz, logic [SLOT_W-1:0] slot);
    request_t r;
    r.action = act;
    r.key    = key;
    r.frc    = {fz, fy, fx};
    r.slot   = slot;
    request_q.push_back(r);
    queued_total++;
  endtask

  task automatic queue_random(int unsigned n, int unsigned add_pct, int unsigned new_pct,
                              bit with_clear);
    logic [ACTION_W-1:0] act;
    int unsigned         r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        act = ACT_ADD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) act = ACT_LOOKUP;
        else if (r < 62) act = ACT_REMOVE;
        else if (r < 88) act = ACT_READ;
        else if (r < 92 && with_clear) act = ACT_CLEAR;
        else act = ACTION_W'($urandom_range(UNUSED_ACT_LO, UNUSED_ACT_HI));
      end
      queue_request(act, pick_key(new_pct), pick_force(), pick_force(), pick_force(),
                    SLOT_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 255)));
    end
  endtask

  task automatic settle();
    while (responses_seen != queued_total) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = val[CAP_W-1:0];
    else resv_reg = val;
  endtask

  // Item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.action     <= '0;
      in_if.entity_key <= '0;
      in_if.force_x    <= '0;
      in_if.force_y    <= '0;
      in_if.force_z    <= '0;
      in_if.slot_index <= '0;
      tx_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) response_q.push_back(apply_to_table(tx_item));
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          tx_item = request_q.pop_front();
          in_if.action     <= tx_item.action;
          in_if.entity_key <= tx_item.key;
          in_if.force_x    <= tx_item.frc[0];
          in_if.force_y    <= tx_item.frc[1];
          in_if.force_z    <= tx_item.frc[2];
          in_if.slot_index <= tx_item.slot;
          in_if.valid      <= 1'b1;
          tx_gap = pick_pause(tx_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        responses_seen++;
        if (response_q.size() == 0) begin
          $error("result item with nothing expected: status %0d, entry_total %0d",
                 out_if.status, out_if.entry_total);
          fail_cnt++;
        end else begin
          want = response_q.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("out_key", want.key, out_if.out_key);
          check_field("out_x", want.vec[0], out_if.out_x);
          check_field("out_y", want.vec[1], out_if.out_y);
          check_field("out_z", want.vec[2], out_if.out_z);
          check_field("entry_total", want.total, out_if.entry_total);
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && responses_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        rx_hold = HOLD_LEN;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        rx_gap = pick_pause(rx_calm);
        out_if.ready <= (rx_gap == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_CAPACITY;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    cap_reg          = CAP_RESET;
    resv_reg         = '0;
    tbl_count        = 0;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = $urandom();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, reserved key, saturation, swap on remove, unused actions
    queue_request(ACT_LOOKUP, 32'd5, '0, '0, '0, '0);
    queue_request(ACT_REMOVE, 32'd5, '0, '0, '0, '0);
    queue_request(ACT_READ, '0, '0, '0, '0, '0);
    queue_request(ACT_ADD, '0, Q_ONE, Q_ONE, Q_ONE, '0);
    queue_request(ACT_LOOKUP, '0, '0, '0, '0, '0);
    queue_request(ACT_REMOVE, '0, '0, '0, '0, '0);
    queue_request(ACT_ADD, '1, Q_MAX, Q_MIN, '0, '0);
    queue_request(ACT_ADD, '1, Q_MAX, Q_MIN, '1, '0);
    queue_request(ACT_ADD, 32'd1, Q_ONE, 32'h0002_0000, 32'h0003_8000, '0);
    queue_request(ACT_ADD, 32'd2, -Q_ONE, 32'h0007_0000, 32'h1234_5678, '0);
    queue_request(ACT_LOOKUP, 32'd1, '0, '0, '0, '0);
    queue_request(ACT_READ, '0, '0, '0, '0, 8'd0);
    queue_request(ACT_READ, '0, '0, '0, '0, 8'd2);
    queue_request(ACT_READ, '0, '0, '0, '0, 8'd3);
    queue_request(ACT_READ, '1, '1, '1, '1, '1);
    queue_request(ACT_REMOVE, '1, '0, '0, '0, '0);
    queue_request(ACT_READ, '0, '0, '0, '0, 8'd0);
    queue_request(ACT_REMOVE, 32'd2, '0, '0, '0, '0);
    queue_request(ACT_LOOKUP, 32'd2, '0, '0, '0, '0);
    for (int a = UNUSED_ACT_LO; a <= UNUSED_ACT_HI; a++)
      queue_request(ACTION_W'(a), 32'd1, $urandom(), $urandom(), $urandom(),
                    SLOT_W'($urandom()));
    queue_request(ACT_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                  SLOT_W'($urandom()));
    queue_request(ACT_READ, '0, '0, '0, '0, 8'd0);
    queue_request(ACT_LOOKUP, 32'd1, '0, '0, '0, '0);
    settle();

    // capacity of one, all-ones reserved key
    set_register(CFG_CAPACITY, 32'd1);
    set_register(CFG_RESERVED, '1);
    queue_request(ACT_ADD, 32'd10, Q_ONE, Q_ONE, Q_ONE, '0);
    queue_request(ACT_ADD, 32'd11, Q_ONE, Q_ONE, Q_ONE, '0);
    queue_request(ACT_ADD, 32'd10, Q_MAX, Q_MIN, -Q_ONE, '0);
    queue_request(ACT_ADD, '1, Q_ONE, Q_ONE, Q_ONE, '0);
    queue_request(ACT_LOOKUP, '0, '0, '0, '0, '0);
    queue_request(ACT_REMOVE, 32'd10, '0, '0, '0, '0);
    queue_request(ACT_ADD, 32'd11, Q_MIN, Q_MAX, '0, '0);
    settle();

    // fill the whole table, then squeeze the capacity below the entry count
    set_register(CFG_CAPACITY, CAP_RESET);
    set_register(CFG_RESERVED, $urandom());
    queue_random(420, 90, 75, 1'b0);
    settle();
    set_register(CFG_CAPACITY, 32'd4);
    queue_random(120, 40, 10, 1'b1);
    settle();
    set_register(CFG_CAPACITY, 32'd1);
    set_register(CFG_RESERVED, '0);
    queue_random(80, 50, 10, 1'b1);
    settle();
    set_register(CFG_CAPACITY, $urandom_range(2, 255));
    set_register(CFG_RESERVED, $urandom_range(0, 1) ? key_pool[0] : $urandom());
    queue_random(200, 55, 15, 1'b1);
    settle();

    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
